// File: hdl/nft_pkg.sv
// ----------------------------------------------------------------------------
// nft_pkg
// shared types and constants for the nat flow table with idle expiry
// ----------------------------------------------------------------------------
package nft_pkg;

  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 104;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_EXT_ADDR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PORT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAN_DEV    = 3'd4;

  typedef struct packed {
    logic        valid;
    logic [31:0] inner_addr;
    logic [15:0] inner_port;
    logic [31:0] remote_addr;
    logic [15:0] remote_port;
    logic [7:0]  proto;
    logic [15:0] outer_port;
    logic [3:0]  dev;
    logic [31:0] last_used;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // take the input word
    logic scan_start;  // start a sweep over the table
    logic scan_exp;    // sweep looks for the oldest flow
    logic retire;      // retire oldest flow, push its port
    logic clr_step;    // clear one entry
    logic commit;      // write back, load output register
  } nft_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic refill;
    logic clr_last;
    logic scan_done;
    logic exp_ok;
    logic now_gt_prev;
    logic out_busy;
  } nft_sts_t;

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_EXP     = 6'b000100,
    ST_EXP_DEC = 6'b001000,
    ST_LK      = 6'b010000,
    ST_DONE    = 6'b100000
  } nft_state_t;

endpackage

// File: hdl/nft_ctrl.sv
// ----------------------------------------------------------------------------
// nft_ctrl
// sequencer: clearing pass, expiry sweeps, lookup sweep, result hand-off
// ----------------------------------------------------------------------------
module nft_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  nft_pkg::nft_sts_t sts,
  output nft_pkg::nft_cmd_t cmd,
  output logic              idle
);
  import nft_pkg::*;

  nft_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          cmd.scan_exp   = sts.now_gt_prev;
          state_nxt      = sts.now_gt_prev ? ST_EXP : ST_LK;
        end
      end
      ST_EXP: begin
        if (sts.scan_done) state_nxt = ST_EXP_DEC;
      end
      ST_EXP_DEC: begin
        cmd.scan_start = 1'b1;
        if (sts.exp_ok) begin
          cmd.retire   = 1'b1;
          cmd.scan_exp = 1'b1;
          state_nxt    = ST_EXP;
        end else begin
          state_nxt = ST_LK;
        end
      end
      ST_LK: begin
        if (sts.scan_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
    // a pool refill restarts the clearing pass
    if (sts.refill) state_nxt = ST_CLEAR;
  end

  assign idle = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

// File: hdl/nft_datapath.sv
// ----------------------------------------------------------------------------
// nft_datapath
// flow table memory, free-port stack, config registers, sweep compare, output
// ----------------------------------------------------------------------------
module nft_datapath #(
  parameter int FLOW_CAPACITY = 1024,
  parameter int DEVICE_BITS   = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nft_pkg::nft_cmd_t                   cmd,
  output nft_pkg::nft_sts_t                   sts,
  input  logic [nft_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                in_tuser,
  input  logic                                cfg_valid,
  input  logic [nft_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nft_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [nft_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tuser
);
  import nft_pkg::*;

  localparam int IW = (FLOW_CAPACITY > 1) ? $clog2(FLOW_CAPACITY) : 1;
  localparam int CW = $clog2(FLOW_CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(FLOW_CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT  = CW'(FLOW_CAPACITY);
  // port count after reset, from the reset flow limit of 1024
  localparam logic [CW-1:0] RST_LIM  = (FLOW_CAPACITY > 1024) ? CW'(1024) : CAP_CNT;
  localparam logic [3:0] DEV_MASK =
    (DEVICE_BITS >= 4) ? 4'hF : 4'((1 << DEVICE_BITS) - 1);

  // config registers
  logic [31:0] ext_addr_r, idle_lim_r;
  logic [15:0] first_port_r;
  logic [10:0] flow_lim_r, flow_lim_nxt;
  logic [3:0]  wan_dev_r;
  logic        refill;

  assign refill = cfg_valid &&
                  (cfg_index == REG_FIRST_PORT || cfg_index == REG_FLOW_LIMIT);
  assign flow_lim_nxt = (cfg_valid && cfg_index == REG_FLOW_LIMIT) ? cfg_data[10:0]
                                                                   : flow_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_addr_r   <= '0;
      first_port_r <= '0;
      flow_lim_r   <= 11'd1024;
      idle_lim_r   <= 32'd10;
      wan_dev_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_EXT_ADDR:   ext_addr_r   <= cfg_data;
        REG_FIRST_PORT: first_port_r <= cfg_data[15:0];
        REG_FLOW_LIMIT: flow_lim_r   <= cfg_data[10:0];
        REG_IDLE_LIMIT: idle_lim_r   <= cfg_data;
        REG_WAN_DEV:    wan_dev_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] eff_lim;
  assign eff_lim = ({21'd0, flow_lim_nxt} > 32'(FLOW_CAPACITY)) ? CAP_CNT
                                                                 : CW'(flow_lim_nxt);

  // item registers
  logic [31:0] now_r, sa_r, da_r, prev_r;
  logic [15:0] sp_r, dp_r;
  logic [7:0]  pr_r;
  logic [3:0]  dev_r;
  logic        l4_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r <= in_tdata[31:0];
      dev_r <= in_tdata[35:32] & DEV_MASK;
      sa_r  <= in_tdata[67:36];
      sp_r  <= in_tdata[83:68];
      da_r  <= in_tdata[115:84];
      dp_r  <= in_tdata[131:116];
      pr_r  <= in_tdata[139:132];
      l4_r  <= in_tuser;
    end
  end

  logic [3:0] wan_m;
  logic       is_wan;
  assign wan_m  = wan_dev_r & DEV_MASK;
  assign is_wan = (dev_r == wan_m);

  // flow table memory
  entry_t        tbl_mem [FLOW_CAPACITY];
  entry_t        rd_ent_r;
  logic          tbl_we;
  logic [IW-1:0] tbl_wa;
  entry_t        tbl_wd;

  logic [IW-1:0] rd_idx_r, tag_r, clr_idx_r;
  logic          scan_act_r, rdv_r, scan_exp_r;

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    rd_ent_r <= tbl_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_act_r <= 1'b0;
      rdv_r      <= 1'b0;
      rd_idx_r   <= '0;
      scan_exp_r <= 1'b0;
    end else begin
      rdv_r <= scan_act_r;
      tag_r <= rd_idx_r;
      if (cmd.scan_start) begin
        scan_act_r <= 1'b1;
        rd_idx_r   <= '0;
        scan_exp_r <= cmd.scan_exp;
      end else if (scan_act_r) begin
        if (rd_idx_r == LAST_IDX) scan_act_r <= 1'b0;
        else                      rd_idx_r   <= rd_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)             clr_idx_r <= '0;
    else if (refill)        clr_idx_r <= '0;
    else if (cmd.clr_step)  clr_idx_r <= clr_idx_r + 1'b1;
  end

  // sweep evaluation
  logic   wan_hit, ins_hit, ent_match;
  assign wan_hit = rd_ent_r.valid && rd_ent_r.remote_addr == sa_r &&
                   rd_ent_r.remote_port == sp_r && da_r == ext_addr_r &&
                   rd_ent_r.outer_port == dp_r && rd_ent_r.proto == pr_r;
  assign ins_hit = rd_ent_r.valid && rd_ent_r.inner_addr == sa_r &&
                   rd_ent_r.inner_port == sp_r && rd_ent_r.remote_addr == da_r &&
                   rd_ent_r.remote_port == dp_r && rd_ent_r.proto == pr_r;
  assign ent_match = is_wan ? wan_hit : ins_hit;

  logic          best_fnd_r, hit_r, free_fnd_r;
  logic [IW-1:0] best_idx_r, hit_idx_r, free_idx_r;
  logic [31:0]   best_lu_r;
  logic [15:0]   best_port_r;
  entry_t        hit_ent_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      best_fnd_r <= 1'b0;
      hit_r      <= 1'b0;
      free_fnd_r <= 1'b0;
    end else if (rdv_r) begin
      if (scan_exp_r) begin
        // strict less keeps the lowest index on ties
        if (rd_ent_r.valid && (!best_fnd_r || rd_ent_r.last_used < best_lu_r)) begin
          best_fnd_r  <= 1'b1;
          best_idx_r  <= tag_r;
          best_lu_r   <= rd_ent_r.last_used;
          best_port_r <= rd_ent_r.outer_port;
        end
      end else begin
        if (ent_match && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= tag_r;
          hit_ent_r <= rd_ent_r;
        end
        if (!rd_ent_r.valid && !free_fnd_r) begin
          free_fnd_r <= 1'b1;
          free_idx_r <= tag_r;
        end
      end
    end
  end

  // free-port stack; entries below the low-water mark still hold the reset pattern
  logic [15:0]   stk_mem [FLOW_CAPACITY];
  logic [CW-1:0] cnt_r, lw_r, cnt_m1;
  logic [IW-1:0] stk_ra;
  logic [15:0]   stk_rd_r, pat_r;
  logic          pris_r;
  logic [15:0]   pop_val;
  logic          do_push, do_new;

  assign cnt_m1  = cnt_r - CW'(1);
  assign stk_ra  = cnt_m1[IW-1:0];
  assign pop_val = pris_r ? pat_r : stk_rd_r;
  assign do_push = cmd.retire && (cnt_r < CAP_CNT);

  always_ff @(posedge clk) begin
    if (do_push) stk_mem[cnt_r[IW-1:0]] <= best_port_r;
    stk_rd_r <= stk_mem[stk_ra];
    pris_r   <= (cnt_m1 < lw_r);
    pat_r    <= first_port_r + 16'(stk_ra);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= RST_LIM;
      lw_r  <= RST_LIM;
    end else if (refill) begin
      cnt_r <= eff_lim;
      lw_r  <= eff_lim;
    end else if (do_push) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (do_new) begin
      cnt_r <= cnt_m1;
      if (cnt_m1 < lw_r) lw_r <= cnt_m1;
    end
  end

  // result and write-back
  logic        r_drop;
  logic [3:0]  r_egr;
  logic [31:0] r_nsa, r_nda;
  logic [15:0] r_nsp, r_ndp;
  entry_t      upd_ent;
  logic        upd_we;
  logic [IW-1:0] upd_idx;

  always_comb begin
    r_drop  = 1'b1;
    r_egr   = dev_r;
    r_nsa   = sa_r;
    r_nsp   = sp_r;
    r_nda   = da_r;
    r_ndp   = dp_r;
    upd_ent = hit_ent_r;
    upd_ent.last_used = now_r;
    upd_we  = 1'b0;
    upd_idx = hit_idx_r;
    do_new  = 1'b0;
    if (l4_r && is_wan) begin
      if (hit_r) begin
        upd_we = 1'b1;
        r_drop = 1'b0;
        r_egr  = hit_ent_r.dev;
        r_nda  = hit_ent_r.inner_addr;
        r_ndp  = hit_ent_r.inner_port;
      end
    end else if (l4_r) begin
      if (hit_r) begin
        upd_we = 1'b1;
        r_drop = 1'b0;
        r_egr  = wan_m;
        r_nsa  = ext_addr_r;
        r_nsp  = hit_ent_r.outer_port;
      end else if (cnt_r != '0 && free_fnd_r) begin
        do_new  = cmd.commit;
        upd_we  = 1'b1;
        upd_idx = free_idx_r;
        upd_ent = '{valid: 1'b1, inner_addr: sa_r, inner_port: sp_r,
                    remote_addr: da_r, remote_port: dp_r, proto: pr_r,
                    outer_port: pop_val, dev: dev_r, last_used: now_r};
        r_drop  = 1'b0;
        r_egr   = wan_m;
        r_nsa   = ext_addr_r;
        r_nsp   = pop_val;
      end
    end
  end

  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = upd_idx;
    tbl_wd = upd_ent;
    priority if (cmd.clr_step) begin
      tbl_we = 1'b1;
      tbl_wa = clr_idx_r;
      tbl_wd = '0;
    end else if (cmd.retire) begin
      tbl_we = 1'b1;
      tbl_wa = best_idx_r;
      tbl_wd = '0;
    end else if (cmd.commit) begin
      tbl_we = upd_we;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          prev_r <= '0;
    else if (cmd.commit) prev_r <= now_r;
  end

  // output register
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n)                   out_valid_r <= 1'b0;
    else if (cmd.commit)          out_valid_r <= 1'b1;
    else if (out_tready)          out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_tuser <= r_drop;
      out_tdata <= {4'd0, r_ndp, r_nda, r_nsp, r_nsa, r_egr};
    end
  end

  assign out_tvalid = out_valid_r;

  assign sts.refill      = refill;
  assign sts.clr_last    = (clr_idx_r == LAST_IDX);
  assign sts.scan_done   = rdv_r && (tag_r == LAST_IDX);
  assign sts.exp_ok      = best_fnd_r && (best_lu_r <= prev_r) &&
                           ((prev_r - best_lu_r) > idle_lim_r);
  assign sts.now_gt_prev = (in_tdata[31:0] > prev_r);
  assign sts.out_busy    = out_valid_r;

endmodule

// File: hdl/nat_flow_table_with_expiry.sv
// ----------------------------------------------------------------------------
// nat_flow_table_with_expiry
// port-translating flow table with idle expiry, one result word per input word
// ----------------------------------------------------------------------------
// sequence: expiry sweeps over the N entries (N = FLOW_CAPACITY), then a lookup sweep;
//   one expiry sweep per retired flow plus one when time advances
// throughput: one word at a time, the next taken once the last result is committed; a waiting
//   result holds the next one back; sweeps read the table memory one entry a cycle
// reset: synchronous active low; then a clearing pass over all N entries, repeated after
//   each write of first_port or flow_limit; input not taken meanwhile
module nat_flow_table_with_expiry #(
  parameter int FLOW_CAPACITY = 1024,
  parameter int DEVICE_BITS   = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // now, in_device, source_address, source_port, dest_address, dest_port,
  // protocol, zero pad
  input  logic [nft_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,  // is_ipv4_l4
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // egress_device, new_source_address, new_source_port, new_dest_address,
  // new_dest_port, zero pad
  output logic [nft_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser, // drop
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nft_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nft_pkg::*;

  nft_cmd_t cmd;
  nft_sts_t sts;
  logic     idle, in_accept;

  assign cfg_ready = 1'b1;
  assign in_tready = idle;
  assign in_accept = in_tvalid && in_tready;

  nft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .sts       (sts),
    .cmd       (cmd),
    .idle      (idle)
  );

  nft_datapath #(
    .FLOW_CAPACITY (FLOW_CAPACITY),
    .DEVICE_BITS   (DEVICE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !out_tvalid)
    else $error("result overwritten");

  // taking a word leaves the block busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("ready right after accept");

  // a refill always starts the clearing pass
  a_refill_clear: assert property (@(posedge clk) disable iff (!rst_n)
    sts.refill |=> !in_tready)
    else $error("ready during clearing pass");

endmodule
